// ----- rtl/core/jsu_pkg.sv -----
// Types, constants and helpers shared by the JSON string unescape core.
`default_nettype none

package jsu_pkg;

  localparam int unsigned MaxRes = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [15:0] HiFirst = 16'hD800;
  localparam logic [15:0] HiLast  = 16'hDBFF;
  localparam logic [15:0] LoFirst = 16'hDC00;
  localparam logic [15:0] LoLast  = 16'hDFFF;
  localparam logic [7:0]  CtrlTop = 8'h20;

  typedef enum logic [1:0] {
    KindRaw  = 2'd0,
    KindUnit = 2'd1,
    KindEnd  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    StOk         = 4'd0,
    StTruncEsc   = 4'd1,
    StTruncUni   = 4'd2,
    StBadHex     = 4'd3,
    StBadEsc     = 4'd4,
    StHiUnpaired = 4'd5,
    StBadPair    = 4'd6,
    StLoUnpaired = 4'd7,
    StCtrl       = 4'd8
  } status_e;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] unit_value;
    logic [3:0]  status;
    logic        done_res;
  } out_item_t;

  // bit 4 set when the byte is a hex digit, bits 3:0 its value
  function automatic logic [4:0] hex_decode(logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/json_string_unescape_core.sv -----
// JSON string body unescape core: byte-wise decoder with a small result queue.
//
//   channel  | signals                         | transaction
//   ---------+---------------------------------+---------------------------------
//   input    | in_valid_i  in_stall_o in_data_i  | one string byte and last flag
//   output   | out_valid_o out_stall_i out_data_o| raw byte, code unit or end item
//
// One input byte per cycle unless in_stall_o is high; the decoder is a single
// register stage and its 0 to 3 results go into a 4-entry queue drained one per
// cycle while out_stall_i is low. Input stalls while the queue holds more than
// one entry (room for 3 needed). A result appears at the earliest in the cycle
// after its byte is accepted. Reset clears decoder state and empties the queue.
`default_nettype none

module json_string_unescape_core
  import jsu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  typedef enum logic [2:0] {
    ModePlain,
    ModeEsc,
    ModeHex,
    ModePairBs,
    ModePairU,
    ModeLow,
    ModeError
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [1:0]  dig_q, dig_d;
  logic [15:0] acc_q, acc_d;
  logic [15:0] hi_q, hi_d;
  logic        bad_q, bad_d;
  logic [3:0]  err_q, err_d;

  out_item_t   mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  out_item_t   res [MaxRes];
  logic [1:0]  n_res;
  logic [4:0]  hexv;
  logic [15:0] acc_dig;
  logic        bad_dig;
  logic [7:0]  b;
  logic        last;
  logic        accept, pop;

  assign b       = in_data_i.byte_req;
  assign last    = in_data_i.last;
  assign hexv    = hex_decode(b);
  assign acc_dig = hexv[4] ? {acc_q[11:0], hexv[3:0]} : acc_q;
  assign bad_dig = bad_q | ~hexv[4];

  always_comb begin
    mode_d = mode_q;
    dig_d  = dig_q;
    acc_d  = acc_q;
    hi_d   = hi_q;
    bad_d  = bad_q;
    err_d  = err_q;
    n_res  = 2'd0;
    for (int i = 0; i < MaxRes; i++) begin
      res[i] = '0;
    end

    case (mode_q)
      ModeError: begin
      end
      ModeEsc: begin
        case (b)
          8'h6E, 8'h72, 8'h74, 8'h62, 8'h66, 8'h22, 8'h5C, 8'h2F: begin
            res[0].kind = KindUnit;
            case (b)
              8'h6E:   res[0].unit_value = 16'h000A;
              8'h72:   res[0].unit_value = 16'h000D;
              8'h74:   res[0].unit_value = 16'h0009;
              8'h62:   res[0].unit_value = 16'h0008;
              8'h66:   res[0].unit_value = 16'h000C;
              default: res[0].unit_value = {8'h00, b};
            endcase
            n_res  = 2'd1;
            mode_d = ModePlain;
          end
          8'h75: begin
            acc_d  = '0;
            bad_d  = 1'b0;
            dig_d  = 2'd0;
            mode_d = ModeHex;
            if (last) begin
              err_d  = StTruncUni;
              mode_d = ModeError;
            end
          end
          default: begin
            err_d  = StBadEsc;
            mode_d = ModeError;
          end
        endcase
      end
      ModeHex: begin
        acc_d = acc_dig;
        bad_d = bad_dig;
        if (dig_q == 2'd3) begin
          if (bad_dig) begin
            err_d  = StBadHex;
            mode_d = ModeError;
          end else if (acc_dig inside {[HiFirst:HiLast]}) begin
            hi_d   = acc_dig;
            mode_d = ModePairBs;
            if (last) begin
              err_d  = StHiUnpaired;
              mode_d = ModeError;
            end
          end else if (acc_dig inside {[LoFirst:LoLast]}) begin
            err_d  = StLoUnpaired;
            mode_d = ModeError;
          end else begin
            res[0].kind       = KindUnit;
            res[0].unit_value = acc_dig;
            n_res             = 2'd1;
            mode_d            = ModePlain;
          end
        end else begin
          dig_d = dig_q + 2'd1;
          if (last) begin
            err_d  = StTruncUni;
            mode_d = ModeError;
          end
        end
      end
      ModePairBs: begin
        if (b != 8'h5C || last) begin
          err_d  = StHiUnpaired;
          mode_d = ModeError;
        end else begin
          mode_d = ModePairU;
        end
      end
      ModePairU: begin
        if (b != 8'h75 || last) begin
          err_d  = StHiUnpaired;
          mode_d = ModeError;
        end else begin
          acc_d  = '0;
          bad_d  = 1'b0;
          dig_d  = 2'd0;
          mode_d = ModeLow;
        end
      end
      ModeLow: begin
        acc_d = acc_dig;
        bad_d = bad_dig;
        if (dig_q == 2'd3) begin
          if (bad_dig) begin
            err_d  = StBadHex;
            mode_d = ModeError;
          end else if (!(acc_dig inside {[LoFirst:LoLast]})) begin
            err_d  = StBadPair;
            mode_d = ModeError;
          end else begin
            res[0].kind       = KindUnit;
            res[0].unit_value = hi_q;
            res[1].kind       = KindUnit;
            res[1].unit_value = acc_dig;
            n_res             = 2'd2;
            mode_d            = ModePlain;
          end
        end else begin
          dig_d = dig_q + 2'd1;
          if (last) begin
            err_d  = StHiUnpaired;
            mode_d = ModeError;
          end
        end
      end
      default: begin
        if (b == 8'h5C) begin
          if (last) begin
            err_d  = StTruncEsc;
            mode_d = ModeError;
          end else begin
            mode_d = ModeEsc;
          end
        end else if (b < CtrlTop) begin
          err_d  = StCtrl;
          mode_d = ModeError;
        end else begin
          res[0].kind       = KindRaw;
          res[0].unit_value = {8'h00, b};
          n_res             = 2'd1;
          mode_d            = ModePlain;
        end
      end
    endcase

    if (last) begin
      res[n_res].kind       = KindEnd;
      res[n_res].unit_value = '0;
      res[n_res].status     = err_d;
      res[n_res].done_res   = 1'b1;
      n_res  = n_res + 2'd1;
      mode_d = ModePlain;
      dig_d  = '0;
      acc_d  = '0;
      hi_d   = '0;
      bad_d  = 1'b0;
      err_d  = StOk;
    end
  end

  assign in_stall_o  = cnt_q > QCntW'(QDepth - MaxRes);
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & ~out_stall_i;
  assign cnt_d       = cnt_q + (accept ? QCntW'(n_res) : '0) - QCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModePlain;
      dig_q    <= '0;
      acc_q    <= '0;
      hi_q     <= '0;
      bad_q    <= 1'b0;
      err_q    <= StOk;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (accept) begin
        mode_q   <= mode_d;
        dig_q    <= dig_d;
        acc_q    <= acc_d;
        hi_q     <= hi_d;
        bad_q    <= bad_d;
        err_q    <= err_d;
        wr_ptr_q <= wr_ptr_q + QPtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // queue storage, pointers wrap since the depth is a power of two
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < MaxRes; i++) begin
        if (2'(i) < n_res) begin
          mem_q[wr_ptr_q + QPtrW'(i)] <= res[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sim/json_unescape_checker.sv -----
// Checker for the JSON string unescape core: decodes accepted bytes and compares the results.
module json_unescape_checker
  import jsu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [7:0] LetterU   = 8'h75;

  typedef enum logic [3:0] {
    ModePlain  = 4'd0,
    ModeEsc    = 4'd1,
    ModeHex0   = 4'd2,
    ModeHex1   = 4'd3,
    ModeHex2   = 4'd4,
    ModeHex3   = 4'd5,
    ModePairBs = 4'd6,
    ModePairU  = 4'd7,
    ModeLow0   = 4'd8,
    ModeLow1   = 4'd9,
    ModeLow2   = 4'd10,
    ModeLow3   = 4'd11,
    ModeError  = 4'd12
  } mode_e;

  mode_e       mode;
  logic [15:0] acc;
  logic [15:0] hi_half;
  logic        digit_bad;
  status_e     err;
  out_item_t   decoded_q[$];
  int          errors = 0;

  assign fail_count_o = errors;

  // bit 4 flags a valid hex digit
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return {1'b1, c[3:0]};
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  task automatic clear_state();
    mode      = ModePlain;
    acc       = 16'd0;
    hi_half   = 16'd0;
    digit_bad = 1'b0;
    err       = StOk;
  endtask

  task automatic emit(kind_e k, logic [15:0] v, status_e s, logic d);
    out_item_t it;
    it.kind       = k;
    it.unit_value = v;
    it.status     = s;
    it.done_res   = d;
    decoded_q.insert(decoded_q.size(), it);
  endtask

  // first error wins, everything after is dropped
  task automatic note_error(status_e s);
    if (err == StOk) err = s;
    mode = ModeError;
  endtask

  task automatic take_digit(logic [7:0] c);
    logic [4:0] h;
    h = nibble_of(c);
    if (!h[4]) digit_bad = 1'b1;
    else acc = {acc[11:0], h[3:0]};
  endtask

  task automatic decode_byte(logic [7:0] b, logic lst);
    logic [15:0] u;
    logic        ok;
    case (mode)
      ModeError: ;
      ModeEsc: begin
        ok = 1'b1;
        u  = 16'd0;
        case (b)
          8'h6E: u = 16'h000A;
          8'h72: u = 16'h000D;
          8'h74: u = 16'h0009;
          8'h62: u = 16'h0008;
          8'h66: u = 16'h000C;
          8'h22, 8'h5C, 8'h2F: u = {8'h00, b};
          default: ok = 1'b0;
        endcase
        if (ok) begin
          emit(KindUnit, u, StOk, 1'b0);
          mode = ModePlain;
        end else if (b == LetterU) begin
          acc       = 16'd0;
          digit_bad = 1'b0;
          mode      = ModeHex0;
          if (lst) note_error(StTruncUni);
        end else begin
          note_error(StBadEsc);
        end
      end
      ModeHex0, ModeHex1, ModeHex2: begin
        take_digit(b);
        mode = mode_e'(mode + 4'd1);
        if (lst) note_error(StTruncUni);
      end
      ModeHex3: begin
        take_digit(b);
        if (digit_bad) begin
          note_error(StBadHex);
        end else if (acc >= HiFirst && acc <= HiLast) begin
          hi_half = acc;
          mode    = ModePairBs;
          if (lst) note_error(StHiUnpaired);
        end else if (acc >= LoFirst && acc <= LoLast) begin
          note_error(StLoUnpaired);
        end else begin
          emit(KindUnit, acc, StOk, 1'b0);
          mode = ModePlain;
        end
      end
      ModePairBs: begin
        if (b != Backslash || lst) note_error(StHiUnpaired);
        else mode = ModePairU;
      end
      ModePairU: begin
        if (b != LetterU || lst) begin
          note_error(StHiUnpaired);
        end else begin
          acc       = 16'd0;
          digit_bad = 1'b0;
          mode      = ModeLow0;
        end
      end
      ModeLow0, ModeLow1, ModeLow2: begin
        take_digit(b);
        mode = mode_e'(mode + 4'd1);
        if (lst) note_error(StHiUnpaired);
      end
      ModeLow3: begin
        take_digit(b);
        if (digit_bad) begin
          note_error(StBadHex);
        end else if (acc < LoFirst || acc > LoLast) begin
          note_error(StBadPair);
        end else begin
          emit(KindUnit, hi_half, StOk, 1'b0);
          emit(KindUnit, acc, StOk, 1'b0);
          mode = ModePlain;
        end
      end
      default: begin
        if (b == Backslash) begin
          if (lst) note_error(StTruncEsc);
          else mode = ModeEsc;
        end else if (b < CtrlTop) begin
          note_error(StCtrl);
        end else begin
          emit(KindRaw, {8'h00, b}, StOk, 1'b0);
          mode = ModePlain;
        end
      end
    endcase
    if (lst) begin
      emit(KindEnd, 16'd0, err, 1'b1);
      clear_state();
    end
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      decoded_q.delete();
      clear_state();
      pending_o <= 0;
    end else begin
      // results only follow earlier bytes, so retire before predicting
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected transaction: kind %0d value %h status %0d done %b",
                 out_data_i.kind, out_data_i.unit_value, out_data_i.status,
                 out_data_i.done_res);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_data_i.kind));
          check_field("unit_value", want.unit_value, out_data_i.unit_value);
          check_field("status", 16'(want.status), 16'(out_data_i.status));
          check_field("done_res", 16'(want.done_res), 16'(out_data_i.done_res));
        end
      end
      if (in_valid_i && !in_stall_i) decode_byte(in_data_i.byte_req, in_data_i.last);
      pending_o <= decoded_q.size();
    end
  end

endmodule

// ----- sim/tb_json_string_unescape_core.sv -----
// Testbench top for the JSON string unescape core: stimulus, flow control and verdict.
module tb_json_string_unescape_core
  import jsu_pkg::*;
();

  localparam logic [7:0]  Backslash  = 8'h5C;
  localparam logic [7:0]  LetterU    = 8'h75;
  localparam logic [63:0] EscLetters = "nrtbf\"\\/";

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  int        fail_count;
  int        pending;

  logic [7:0] body_q[$];
  int         bytes_sent = 0;
  int         burst_left = 5;

  json_string_unescape_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  json_unescape_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic append_byte(logic [7:0] b);
    body_q.insert(body_q.size(), b);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] d);
    if (d < 4'd10) return 8'h30 + 8'(d);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(d) - 8'd10;
  endfunction

  task automatic add_unit(logic [15:0] v);
    append_byte(Backslash);
    append_byte(LetterU);
    for (int i = 3; i >= 0; i--) append_byte(hex_char(v[i*4 +: 4]));
  endtask

  task automatic load_text(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  function automatic logic [15:0] rand_hi();
    return HiFirst | 16'($urandom_range(0, 16'h3FF));
  endfunction

  function automatic logic [15:0] rand_lo();
    return LoFirst | 16'($urandom_range(0, 16'h3FF));
  endfunction

  task automatic add_token();
    logic [15:0] v;
    logic [7:0]  b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        b = 8'($urandom_range(8'h20, 8'hFF));
        if (b == Backslash) b = 8'hFF;
        append_byte(b);
      end
      4, 5: begin
        append_byte(Backslash);
        append_byte(EscLetters[8*$urandom_range(0, 7) +: 8]);
      end
      6, 7: begin
        v = 16'($urandom);
        if (v inside {[HiFirst:LoLast]}) v = v ^ 16'h4000;
        add_unit(v);
      end
      8: add_unit($urandom_range(0, 1) ? 16'h0000 : 16'hFFFF);
      default: begin
        add_unit(rand_hi());
        add_unit(rand_lo());
      end
    endcase
  endtask

  task automatic add_fault();
    logic [15:0] v;
    logic [7:0]  b;
    case ($urandom_range(0, 5))
      0: append_byte(8'($urandom_range(0, 8'h1F)));
      1: begin
        b = 8'($urandom);
        if (b inside {8'h6E, 8'h72, 8'h74, 8'h62, 8'h66, 8'h22, 8'h5C, 8'h2F, LetterU})
          b = 8'h78;
        append_byte(Backslash);
        append_byte(b);
      end
      2: begin
        if ($urandom_range(0, 1)) begin
          add_unit(16'($urandom));
        end else begin
          add_unit(rand_hi());
          add_unit(rand_lo());
        end
        b = 8'($urandom);
        if (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]}) b = 8'h47;
        body_q[body_q.size() - 1 - $urandom_range(0, 3)] = b;
      end
      3: add_unit(rand_lo());
      4: begin
        add_unit(rand_hi());
        case ($urandom_range(0, 2))
          0: ;
          1: append_byte(8'h41);
          default: begin
            append_byte(Backslash);
            append_byte(8'h6E);
          end
        endcase
      end
      default: begin
        add_unit(rand_hi());
        v = 16'($urandom);
        if (v inside {[LoFirst:LoLast]}) v = v ^ 16'h2000;
        add_unit(v);
      end
    endcase
  endtask

  // well-formed bodies, some with one fault, some cut short, some noise
  task automatic make_body();
    int roll;
    int tokens;
    int bad_at;
    int cut;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      repeat ($urandom_range(1, 10)) append_byte(8'($urandom));
    end else begin
      tokens = $urandom_range(1, 6);
      bad_at = (roll < 40) ? $urandom_range(0, tokens - 1) : -1;
      for (int t = 0; t < tokens; t++) begin
        if (t == bad_at) add_fault();
        else add_token();
      end
      if (roll >= 40 && roll < 52) begin
        cut = $urandom_range(1, body_q.size());
        while (body_q.size() > cut) body_q.delete(body_q.size() - 1);
      end
    end
  endtask

  task automatic send_byte(logic [7:0] b, logic lst);
    in_valid <= 1'b1;
    in_data  <= {b, lst};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      in_data  <= {8'($urandom), 1'($urandom)};
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
    end
  endtask

  task automatic send_body();
    for (int i = 0; i < body_q.size(); i++) send_byte(body_q[i], i == body_q.size() - 1);
    body_q.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stall patterns with an occasional long hold-off
  initial begin
    int phase;
    int span;
    int pct;
    phase = 0;
    forever begin
      phase++;
      if (phase % 9 == 4) begin
        repeat ($urandom_range(40, 80)) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        span = $urandom_range(5, 40);
        case ($urandom_range(0, 2))
          0: pct = 0;
          1: pct = 50;
          default: pct = 80;
        endcase
        repeat (span) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    int start;
    int next_drain;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    append_byte(8'h20);
    append_byte(8'hFF);
    send_body();
    append_byte(8'h00);
    send_body();
    append_byte(8'h1F);
    load_text("a");
    send_body();
    load_text("\\");
    send_body();
    load_text("\\qA");
    send_body();
    load_text("\\u");
    send_body();
    load_text("\\uFFFF");
    send_body();
    load_text("\\uDC00");
    send_body();
    load_text("\\n");
    send_body();
    drain();

    start      = bytes_sent;
    next_drain = 100;
    while (bytes_sent - start < 320) begin
      make_body();
      send_body();
      if (bytes_sent - start >= next_drain) begin
        drain();
        next_drain += 100;
      end
    end

    drain();
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
